// ----- design/dirty_page_framebuffer_assert.svh -----
// assertion macros for the dirty page framebuffer
`ifndef DIRTY_PAGE_FRAMEBUFFER_ASSERT_SVH
`define DIRTY_PAGE_FRAMEBUFFER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define DPF_ASSERT_IMPL(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");
`define DPF_ASSERT_NEXT(label, clk, rst_n, cond, nxt) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) \
		else $error("assertion failed");
`else
`define DPF_ASSERT_IMPL(label, clk, rst_n, prop)
`define DPF_ASSERT_NEXT(label, clk, rst_n, cond, nxt)
`endif
`endif

// ----- design/dpf_pkg.sv -----
// ----------------------------------------------------------------------------
// dpf_pkg
// types and constants shared by the dirty page framebuffer
// ----------------------------------------------------------------------------
package dpf_pkg;
	localparam int PAGE_COUNT_DEF = 8;
	localparam int SCREEN_WIDTH_DEF = 128;
	localparam int SCREEN_HEIGHT_DEF = 64;
	localparam int STORE_COLS = 128;
	localparam int STORE_DEPTH = 1024;
	localparam logic [7:0] CMD_PAGE = 8'hB8;
	localparam logic [7:0] CMD_COLUMN = 8'h40;

	typedef enum logic [1:0] {OP_PLOT = 2'd0, OP_CLEAR = 2'd1, OP_FLUSH = 2'd2,
		OP_NONE = 2'd3} op_t;
	typedef enum logic [1:0] {MODE_OFF = 2'd0, MODE_ON = 2'd1, MODE_TOGGLE = 2'd2,
		MODE_ALT = 2'd3} mode_t;
	typedef enum logic [1:0] {KIND_STATUS = 2'd0, KIND_CMD = 2'd1,
		KIND_DATA = 2'd2, KIND_RSVD = 2'd3} kind_t;
	typedef enum logic [1:0] {CS_NONE = 2'd0, CS_LEFT = 2'd1, CS_RHALF = 2'd2,
		CS_BOTH = 2'd3} cs_t;
	typedef enum logic [2:0] {ST_IDLE, ST_PLOT, ST_CLR_SCAN, ST_CLR_WIPE,
		ST_FL_HEAD, ST_FL_COL, ST_FL_DATA, ST_STATUS} back_state_t;

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] x;
		logic [7:0] y;
		logic [1:0] mode;
		logic [2:0] page;
		logic force_req;
	} in_word_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [1:0] chip_select;
		logic [7:0] command_byte;
		logic [63:0] data_word;
		logic changed;
		logic [7:0] dirty_mask;
		logic last;
	} out_word_t;

	// classified job from the front to the back
	typedef struct packed {
		op_t op;
		logic valid_pix;
		logic [9:0] addr;
		logic [7:0] bitmask;
		logic [1:0] mode;
		logic [2:0] page;
		logic flush_ok;
		logic force_req;
	} job_t;
endpackage

// ----- design/dirty_page_framebuffer.sv -----
// ----------------------------------------------------------------------------
// dirty_page_framebuffer
// monochrome page framebuffer with per-page dirty tracking and page flush
// ----------------------------------------------------------------------------
// input queue: push an in_word while full is low; each word is one operation
// (plot, clear, flush or none). result queue: while empty is low, out_word
// holds the oldest result; pop takes it. every operation ends with a result
// marked last. a plot takes the job, reads the frame store byte, then writes
// it with its result; the next job is taken after that. a clear walks every
// page, reading each column, and wipes and marks dirty each page with a set
// bit; a flush of a dirty page, or a forced one, gives 19 results, the bytes
// read one at a time by the single store port; else one status result. a
// two-entry job queue parts input and back end. reset empties both queues and
// blanks the dirty bits; the back end then zeroes all 1024 frame store bytes
// before the first job, while input is queued. a stalled result queue holds
// the back end at its next result; input is taken until the job queue fills.
// ----------------------------------------------------------------------------
module dirty_page_framebuffer #(
	parameter int PAGE_COUNT = dpf_pkg::PAGE_COUNT_DEF,
	parameter int SCREEN_WIDTH = dpf_pkg::SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = dpf_pkg::SCREEN_HEIGHT_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	input dpf_pkg::in_word_t in_word,
	output logic full,
	output logic empty,
	output dpf_pkg::out_word_t out_word,
	input logic pop
);
	logic job_valid, job_take;
	dpf_pkg::job_t job;

	dpf_front #(.PAGE_COUNT(PAGE_COUNT), .SCREEN_WIDTH(SCREEN_WIDTH),
		.SCREEN_HEIGHT(SCREEN_HEIGHT)) u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .in_word(in_word), .full(full),
		.job_valid(job_valid), .job(job), .job_take(job_take));

	dpf_back #(.PAGE_COUNT(PAGE_COUNT)) u_back (
		.clk(clk), .arst_n(arst_n), .job_valid(job_valid), .job(job),
		.job_take(job_take), .empty(empty), .out_word(out_word), .pop(pop));
endmodule

// ----- design/dpf_front.sv -----
// ----------------------------------------------------------------------------
// dpf_front
// accepts input words, classifies them and queues jobs for the back end
// ----------------------------------------------------------------------------
module dpf_front #(
	parameter int PAGE_COUNT = dpf_pkg::PAGE_COUNT_DEF,
	parameter int SCREEN_WIDTH = dpf_pkg::SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = dpf_pkg::SCREEN_HEIGHT_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	input dpf_pkg::in_word_t in_word,
	output logic full,
	output logic job_valid,
	output dpf_pkg::job_t job,
	input logic job_take
);
	dpf_pkg::job_t q_mem_q [2];
	logic [1:0] cnt_q;
	logic rd_q, wr_q;
	dpf_pkg::job_t cls;
	logic do_push, do_pop;

	always_comb begin
		cls.op = dpf_pkg::op_t'(in_word.op);
		cls.valid_pix = (32'(in_word.x) < SCREEN_WIDTH) && (32'(in_word.y) < SCREEN_HEIGHT)
			&& (32'(in_word.y[7:3]) < PAGE_COUNT);
		cls.addr = {in_word.y[5:3], in_word.x[6:0]};
		cls.bitmask = 8'(1) << in_word.y[2:0];
		cls.mode = in_word.mode;
		cls.page = in_word.page;
		cls.flush_ok = 32'(in_word.page) < PAGE_COUNT;
		cls.force_req = in_word.force_req;
	end

	assign full = cnt_q == 2'd2;
	assign do_push = push && !full;
	assign job_valid = cnt_q != 2'd0;
	assign do_pop = job_take && job_valid;
	assign job = q_mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			q_mem_q[wr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			rd_q <= 1'b0;
			wr_q <= 1'b0;
		end else begin
			if (do_push) wr_q <= !wr_q;
			if (do_pop) rd_q <= !rd_q;
			cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
		end
	end
endmodule

// ----- design/dpf_back.sv -----
// ----------------------------------------------------------------------------
// dpf_back
// executes jobs against the frame store and emits result words;
// zeroes all 1024 frame store bytes after reset
// ----------------------------------------------------------------------------
`include "dirty_page_framebuffer_assert.svh"
module dpf_back #(
	parameter int PAGE_COUNT = dpf_pkg::PAGE_COUNT_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic job_valid,
	input dpf_pkg::job_t job,
	output logic job_take,
	output logic empty,
	output dpf_pkg::out_word_t out_word,
	input logic pop
);
	logic [7:0] mem_q [dpf_pkg::STORE_DEPTH];
	logic [7:0] rdata_q;
	dpf_pkg::back_state_t st_q, st_d;
	dpf_pkg::job_t job_q;
	logic [7:0] dirty_q;
	logic [3:0] pg_q;
	logic [7:0] col_q;
	logic rd_pend_q;
	logic used_q;
	logic [63:0] acc_q;
	logic [1:0] half_q;
	logic [3:0] grp_q;
	logic [2:0] byte_q;
	logic out_full_q;
	dpf_pkg::out_word_t out_q;
	logic init_q;
	logic [9:0] init_cnt_q;

	logic we;
	logic [9:0] waddr, raddr;
	logic [7:0] wdata;
	logic re;
	logic slot_free;
	logic emit;
	dpf_pkg::out_word_t emit_w;
	logic [7:0] after_b;
	logic [7:0] pagebit;

	assign slot_free = !out_full_q || pop;
	assign empty = !out_full_q;
	assign out_word = out_q;
	assign pagebit = 8'(1) << pg_q[2:0];

	always_comb begin
		case (dpf_pkg::mode_t'(job_q.mode))
			dpf_pkg::MODE_ON: after_b = rdata_q | job_q.bitmask;
			dpf_pkg::MODE_OFF: after_b = rdata_q & ~job_q.bitmask;
			default: after_b = rdata_q ^ job_q.bitmask;
		endcase
	end

	// next state
	always_comb begin
		st_d = st_q;
		case (st_q)
			dpf_pkg::ST_IDLE: begin
				if (job_valid && !init_q) begin
					case (job.op)
						dpf_pkg::OP_PLOT: st_d = job.valid_pix ? dpf_pkg::ST_PLOT
							: dpf_pkg::ST_STATUS;
						dpf_pkg::OP_CLEAR: st_d = dpf_pkg::ST_CLR_SCAN;
						dpf_pkg::OP_FLUSH: st_d = (job.flush_ok && (job.force_req
							|| dirty_q[job.page])) ? dpf_pkg::ST_FL_HEAD
							: dpf_pkg::ST_STATUS;
						default: st_d = dpf_pkg::ST_STATUS;
					endcase
				end
			end
			dpf_pkg::ST_PLOT: if (rd_pend_q && slot_free) st_d = dpf_pkg::ST_IDLE;
			dpf_pkg::ST_CLR_SCAN: begin
				if (32'(pg_q) >= PAGE_COUNT) st_d = dpf_pkg::ST_STATUS;
				else if (rd_pend_q && col_q == 8'd128)
					st_d = (used_q || rdata_q != 8'd0) ? dpf_pkg::ST_CLR_WIPE
						: dpf_pkg::ST_CLR_SCAN;
			end
			dpf_pkg::ST_CLR_WIPE: if (col_q == 8'd127) st_d = dpf_pkg::ST_CLR_SCAN;
			dpf_pkg::ST_FL_HEAD: if (slot_free) st_d = dpf_pkg::ST_FL_COL;
			dpf_pkg::ST_FL_COL: if (slot_free) st_d = dpf_pkg::ST_FL_DATA;
			dpf_pkg::ST_FL_DATA: begin
				if (emit && byte_q == 3'd7 && grp_q == 4'd7)
					st_d = half_q == 2'd0 ? dpf_pkg::ST_FL_COL : dpf_pkg::ST_IDLE;
			end
			dpf_pkg::ST_STATUS: if (slot_free) st_d = dpf_pkg::ST_IDLE;
			default: st_d = dpf_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		job_take = st_q == dpf_pkg::ST_IDLE && job_valid && !init_q;
		emit = 1'b0;
		emit_w = '0;
		emit_w.dirty_mask = dirty_q;
		we = 1'b0;
		waddr = job_q.addr;
		wdata = after_b;
		re = 1'b0;
		raddr = job_q.addr;
		case (st_q)
			dpf_pkg::ST_PLOT: begin
				re = !rd_pend_q;
				if (rd_pend_q && slot_free) begin
					emit = 1'b1;
					we = 1'b1;
					emit_w.changed = after_b != rdata_q;
					emit_w.dirty_mask = dirty_q | ((after_b != rdata_q)
						? (8'(1) << job_q.addr[9:7]) : 8'd0);
					emit_w.last = 1'b1;
				end
			end
			dpf_pkg::ST_CLR_SCAN: begin
				re = col_q < 8'd128 && 32'(pg_q) < PAGE_COUNT;
				raddr = {pg_q[2:0], col_q[6:0]};
			end
			dpf_pkg::ST_CLR_WIPE: begin
				we = 1'b1;
				waddr = {pg_q[2:0], col_q[6:0]};
				wdata = 8'd0;
			end
			dpf_pkg::ST_FL_HEAD: begin
				emit = slot_free;
				emit_w.kind = dpf_pkg::KIND_CMD;
				emit_w.chip_select = dpf_pkg::CS_BOTH;
				emit_w.command_byte = dpf_pkg::CMD_PAGE | {5'd0, job_q.page};
				// every word of a flush shows the page already clean
				emit_w.dirty_mask = dirty_q & ~(8'(1) << job_q.page);
			end
			dpf_pkg::ST_FL_COL: begin
				emit = slot_free;
				emit_w.kind = dpf_pkg::KIND_CMD;
				emit_w.chip_select = half_q == 2'd0 ? dpf_pkg::CS_LEFT
					: dpf_pkg::CS_RHALF;
				emit_w.command_byte = dpf_pkg::CMD_COLUMN;
			end
			dpf_pkg::ST_FL_DATA: begin
				re = !rd_pend_q;
				raddr = {job_q.page, half_q[0], grp_q[2:0], byte_q};
				emit = rd_pend_q && byte_q == 3'd7 && slot_free;
				emit_w.kind = dpf_pkg::KIND_DATA;
				emit_w.chip_select = half_q == 2'd0 ? dpf_pkg::CS_LEFT
					: dpf_pkg::CS_RHALF;
				emit_w.data_word = {rdata_q, acc_q[63:8]};
				if (half_q != 2'd0 && grp_q == 4'd7) begin
					emit_w.dirty_mask = dirty_q & ~(8'(1) << job_q.page);
					emit_w.last = 1'b1;
				end
			end
			dpf_pkg::ST_STATUS: begin
				emit = slot_free;
				emit_w.last = 1'b1;
			end
			default: ;
		endcase
		// zeroing pass after reset
		if (init_q) begin
			we = 1'b1;
			waddr = init_cnt_q;
			wdata = 8'd0;
		end
	end

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		if (re) rdata_q <= mem_q[raddr];
	end

	always_ff @(posedge clk) begin
		if (job_take) job_q <= job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= dpf_pkg::ST_IDLE;
			dirty_q <= '0;
			out_full_q <= 1'b0;
			rd_pend_q <= 1'b0;
			pg_q <= '0;
			col_q <= '0;
			used_q <= 1'b0;
			acc_q <= '0;
			half_q <= '0;
			grp_q <= '0;
			byte_q <= '0;
			init_q <= 1'b1;
			init_cnt_q <= '0;
		end else begin
			st_q <= st_d;
			if (init_q) begin
				init_cnt_q <= init_cnt_q + 10'd1;
				if (init_cnt_q == 10'(dpf_pkg::STORE_DEPTH - 1)) init_q <= 1'b0;
			end
			if (emit) out_full_q <= 1'b1;
			else if (pop) out_full_q <= 1'b0;
			if (emit) dirty_q <= emit_w.dirty_mask;
			if (job_take) begin
				pg_q <= '0;
				col_q <= '0;
				used_q <= 1'b0;
				rd_pend_q <= 1'b0;
				half_q <= '0;
				grp_q <= '0;
				byte_q <= '0;
			end
			case (st_q)
				dpf_pkg::ST_PLOT: begin
					if (!rd_pend_q) rd_pend_q <= 1'b1;
				end
				dpf_pkg::ST_CLR_SCAN: begin
					if (32'(pg_q) < PAGE_COUNT) begin
						if (col_q < 8'd128) begin
							col_q <= col_q + 8'd1;
							rd_pend_q <= re;
							if (rd_pend_q && rdata_q != 8'd0) used_q <= 1'b1;
						end else if (rd_pend_q) begin
							col_q <= '0;
							rd_pend_q <= 1'b0;
							if (used_q || rdata_q != 8'd0) begin
								dirty_q <= dirty_q | pagebit;
							end else begin
								pg_q <= pg_q + 4'd1;
							end
							used_q <= 1'b0;
						end
					end
				end
				dpf_pkg::ST_CLR_WIPE: begin
					if (col_q == 8'd127) begin
						col_q <= '0;
						pg_q <= pg_q + 4'd1;
					end else begin
						col_q <= col_q + 8'd1;
					end
				end
				dpf_pkg::ST_FL_DATA: begin
					if (!rd_pend_q) rd_pend_q <= 1'b1;
					else if (byte_q != 3'd7) begin
						acc_q <= {rdata_q, acc_q[63:8]};
						byte_q <= byte_q + 3'd1;
						rd_pend_q <= 1'b0;
					end else if (slot_free) begin
						byte_q <= '0;
						rd_pend_q <= 1'b0;
						if (grp_q == 4'd7) begin
							grp_q <= '0;
							half_q <= half_q + 2'd1;
						end else begin
							grp_q <= grp_q + 4'd1;
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (emit) out_q <= emit_w;
	end

	`DPF_ASSERT_NEXT(a_hold, clk, arst_n, out_full_q && !pop, out_full_q)
	`DPF_ASSERT_IMPL(a_emit_room, clk, arst_n, emit |-> slot_free)
	`DPF_ASSERT_IMPL(a_take_idle, clk, arst_n, job_take |-> st_q == dpf_pkg::ST_IDLE)
endmodule
